// ===== src/smeu_pkg.sv =====
// Package: opcodes, status codes, controller states and command/status structs.
`default_nettype none
package smeu_pkg;
   localparam int STACK_DEPTH = 128;
   localparam int LOCAL_COUNT = 64;
   localparam int SP_W = $clog2(STACK_DEPTH + 1);
   localparam int SA_W = $clog2(STACK_DEPTH);
   localparam int LA_W = (LOCAL_COUNT > 1) ? $clog2(LOCAL_COUNT) : 1;
   localparam int LC_W = $clog2(LOCAL_COUNT + 1);
   localparam int DIV_STEPS = 32;

   localparam logic [3:0] OP_PUSH  = 4'd0;
   localparam logic [3:0] OP_POP   = 4'd1;
   localparam logic [3:0] OP_ADD   = 4'd2;
   localparam logic [3:0] OP_SUB   = 4'd3;
   localparam logic [3:0] OP_MUL   = 4'd4;
   localparam logic [3:0] OP_DIV   = 4'd5;
   localparam logic [3:0] OP_MOD   = 4'd6;
   localparam logic [3:0] OP_CMP   = 4'd7;
   localparam logic [3:0] OP_JF    = 4'd8;
   localparam logic [3:0] OP_JT    = 4'd9;
   localparam logic [3:0] OP_JFWD  = 4'd10;
   localparam logic [3:0] OP_JABS  = 4'd11;
   localparam logic [3:0] OP_LDLOC = 4'd12;
   localparam logic [3:0] OP_STLOC = 4'd13;
   localparam logic [3:0] OP_TOP   = 4'd14;

   localparam logic [15:0] CMP_LT = 16'd0;
   localparam logic [15:0] CMP_LE = 16'd1;
   localparam logic [15:0] CMP_NE = 16'd3;
   localparam logic [15:0] CMP_GT = 16'd4;
   localparam logic [15:0] CMP_GE = 16'd5;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_UNDER = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;
   localparam logic [1:0] ST_DIV0  = 2'd3;

   typedef enum logic [2:0] {
      S_IDLE, S_RD_B, S_RD_A, S_EXEC, S_DIV, S_WB, S_TOP, S_OUT
   } state_type;

   typedef struct packed {
      logic latch;    // capture request
      logic rd_b;     // read stack[sp-1] as b (pops)
      logic rd_a;     // read stack[sp-1] as a (pops)
      logic exec;     // compute result, may start divider
      logic div_step;
      logic wb;       // push / local store
      logic rd_top;   // read top for result
      logic out;      // load output register
   } cmd_type;

   typedef struct packed {
      logic need_b;
      logic need_a;
      logic is_div;
      logic div_done;
      logic clr_busy; // locals still being cleared after reset
   } sts_type;
endpackage
`default_nettype wire

// ===== src/stack_machine_execute_unit_core.sv =====
// Each word steps through one state per step around the single registered stack
// read port, plus the 32-step serial divider for divide or modulo with a nonzero
// divisor, from accepting the word to its result valid.
// One word at a time: the next is taken once the result is registered, and a
// stalled rsp holds it off.
// Reset clears the stack pointer and control; locals are zeroed by a clear
// sweep after reset, and no word is accepted until the sweep is done.
`default_nettype none
module stack_machine_execute_unit_core (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [3:0]         req_opcode,
   input  wire logic [15:0]        req_arg,
   input  wire logic signed [31:0] req_value,
   input  wire logic [15:0]        req_pc,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic signed [31:0]      rsp_top_value,
   output logic [7:0]              rsp_depth,
   output logic                    rsp_branch_valid,
   output logic [15:0]             rsp_next_pc,
   output logic [1:0]              rsp_status
);
   import smeu_pkg::*;
   cmd_type cmd;
   sts_type sts;
   logic out_busy;

   smeu_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .out_busy(out_busy), .sts(sts), .cmd(cmd)
   );

   smeu_dp u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts), .out_busy(out_busy),
      .req_opcode(req_opcode), .req_arg(req_arg), .req_value(req_value), .req_pc(req_pc),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_top_value(rsp_top_value),
      .rsp_depth(rsp_depth), .rsp_branch_valid(rsp_branch_valid),
      .rsp_next_pc(rsp_next_pc), .rsp_status(rsp_status)
   );
endmodule
`default_nettype wire

// ===== src/smeu_ctrl.sv =====
// Controller state machine for the stack machine execute unit.
`default_nettype none
module smeu_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic              out_busy,
   input  wire smeu_pkg::sts_type sts,
   output smeu_pkg::cmd_type      cmd
);
   import smeu_pkg::*;
   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (req_valid && !sts.clr_busy) state_in = S_RD_B;
         S_RD_B: state_in = S_RD_A;
         S_RD_A: state_in = S_EXEC;
         S_EXEC: state_in = sts.is_div ? S_DIV : S_WB;
         S_DIV:  if (sts.div_done) state_in = S_WB;
         S_WB:   state_in = S_TOP;
         S_TOP:  state_in = S_OUT;
         S_OUT:  if (!out_busy) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = !sts.clr_busy;
            cmd.latch = req_valid && !sts.clr_busy;
         end
         S_RD_B: cmd.rd_b = sts.need_b;
         S_RD_A: cmd.rd_a = sts.need_a;
         S_EXEC: cmd.exec = 1'b1;
         S_DIV:  cmd.div_step = 1'b1;
         S_WB:   cmd.wb = 1'b1;
         S_TOP:  cmd.rd_top = 1'b1;
         S_OUT:  cmd.out = !out_busy;
         default: cmd = '0;
      endcase
   end
endmodule
`default_nettype wire

// ===== src/smeu_dp.sv =====
// Datapath: stack memory, locals, ALU, serial divider and result register.
`default_nettype none
module smeu_dp (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire smeu_pkg::cmd_type   cmd,
   output smeu_pkg::sts_type        sts,
   output logic                     out_busy,
   input  wire logic [3:0]          req_opcode,
   input  wire logic [15:0]         req_arg,
   input  wire logic signed [31:0]  req_value,
   input  wire logic [15:0]         req_pc,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic signed [31:0]       rsp_top_value,
   output logic [7:0]               rsp_depth,
   output logic                     rsp_branch_valid,
   output logic [15:0]              rsp_next_pc,
   output logic [1:0]               rsp_status
);
   import smeu_pkg::*;

   logic [31:0] stack_mem [STACK_DEPTH];
   logic [31:0] local_mem [LOCAL_COUNT];
   logic [LC_W-1:0] clr_ff;              // locals cleared below this index

   logic [3:0]  op_ff;
   logic [15:0] arg_ff, pc_ff;
   logic [31:0] val_ff, a_ff, b_ff, res_ff, loc_ff;
   logic [SP_W-1:0] sp_ff;
   logic [1:0]  err_ff;
   logic        bv_ff;
   logic [15:0] npc_ff;
   logic        arg_ok;
   logic        is_bin;

   // divider
   logic [31:0] rem_ff, quo_ff, dvs_ff;
   logic [5:0]  cnt_ff;
   logic        div_na_ff, div_nq_ff;
   logic [32:0] trial;

   assign arg_ok = ({16'd0, arg_ff} < 32'(LOCAL_COUNT));
   assign is_bin = (op_ff >= OP_ADD) && (op_ff <= OP_CMP);
   assign sts.need_b = is_bin || op_ff == OP_POP || op_ff == OP_JF || op_ff == OP_JT
                       || op_ff == OP_STLOC;
   assign sts.need_a = is_bin;
   assign sts.is_div = (op_ff == OP_DIV || op_ff == OP_MOD) && b_ff != 32'd0;
   assign sts.div_done = (cnt_ff == 6'(DIV_STEPS - 1));
   assign sts.clr_busy = (clr_ff != LC_W'(LOCAL_COUNT));
   assign trial = {rem_ff, quo_ff[31]} - {1'b0, dvs_ff};

   // pop flow: the b pop reads ahead at sp-2 so a is ready in S_RD_A
   logic pop_valid;
   assign pop_valid = sp_ff != '0;

   logic [31:0] mem_rd, sp_m1;
   logic [SP_W-1:0] rd_back;
   logic [SA_W-1:0] sp_idx;
   assign rd_back = (cmd.rd_b && pop_valid) ? SP_W'(2) : SP_W'(1);
   assign sp_idx = SA_W'(sp_ff - rd_back);

   always_ff @(posedge clock) begin
      mem_rd <= stack_mem[sp_idx];
      loc_ff <= local_mem[arg_ff[LA_W-1:0]];
   end
   assign sp_m1 = mem_rd;

   logic sa_lt, sa_eq;
   logic [31:0] cmp_res;
   logic signed [31:0] sa, sb;
   assign sa = a_ff;
   assign sb = b_ff;
   assign sa_lt = sa < sb;
   assign sa_eq = sa == sb;
   always_comb begin
      case (arg_ff)
         CMP_LT: cmp_res = {31'd0, sa_lt};
         CMP_LE: cmp_res = {31'd0, sa_lt | sa_eq};
         CMP_NE: cmp_res = {31'd0, !sa_eq};
         CMP_GT: cmp_res = {31'd0, !(sa_lt | sa_eq)};
         CMP_GE: cmp_res = {31'd0, !sa_lt};
         default: cmp_res = {31'd0, sa_eq};
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sp_ff <= '0;
         clr_ff <= '0;
         rsp_valid <= 1'b0;
      end else begin
         if (clr_ff != LC_W'(LOCAL_COUNT)) clr_ff <= clr_ff + LC_W'(1);
         if (rsp_valid && rsp_ready) rsp_valid <= 1'b0;
         if (cmd.out) rsp_valid <= 1'b1;
         if (cmd.rd_b || cmd.rd_a) begin
            if (pop_valid) sp_ff <= sp_ff - SP_W'(1);
         end
         if (cmd.wb) begin
            if (op_ff == OP_PUSH || is_bin || op_ff == OP_LDLOC) begin
               if (sp_ff != SP_W'(STACK_DEPTH)) sp_ff <= sp_ff + SP_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         op_ff <= req_opcode; arg_ff <= req_arg; val_ff <= req_value; pc_ff <= req_pc;
         err_ff <= ST_OK; bv_ff <= 1'b0; npc_ff <= '0;
         a_ff <= '0; b_ff <= '0;
      end
      if (cmd.rd_b) begin
         b_ff <= pop_valid ? sp_m1 : 32'd0;
         if (!pop_valid) err_ff <= ST_UNDER;
      end
      if (cmd.rd_a) begin
         a_ff <= pop_valid ? sp_m1 : 32'd0;
         if (!pop_valid) err_ff <= ST_UNDER;
      end
      if (cmd.exec) begin
         case (op_ff)
            OP_PUSH:  res_ff <= val_ff;
            OP_ADD:   res_ff <= a_ff + b_ff;
            OP_SUB:   res_ff <= a_ff - b_ff;
            OP_MUL:   res_ff <= a_ff * b_ff;
            OP_DIV, OP_MOD: begin
               res_ff <= '0;
               if (b_ff == 32'd0 && err_ff == ST_OK) err_ff <= ST_DIV0;
            end
            OP_CMP:   res_ff <= cmp_res;
            OP_LDLOC: res_ff <= arg_ok ? loc_ff : 32'd0;
            default:  res_ff <= b_ff;
         endcase
         case (op_ff)
            OP_JF:   begin bv_ff <= 1'b1;
                        npc_ff <= (b_ff != 0) ? pc_ff + 16'd2 : arg_ff; end
            OP_JT:   begin bv_ff <= 1'b1;
                        npc_ff <= (b_ff != 0) ? arg_ff : pc_ff + 16'd2; end
            OP_JFWD: begin bv_ff <= 1'b1; npc_ff <= pc_ff + arg_ff; end
            OP_JABS: begin bv_ff <= 1'b1; npc_ff <= arg_ff; end
            OP_TOP:  if (sp_ff == '0) err_ff <= ST_UNDER;
            default: ;
         endcase
         rem_ff <= '0;
         quo_ff <= a_ff[31] ? -a_ff : a_ff;
         dvs_ff <= b_ff[31] ? -b_ff : b_ff;
         div_na_ff <= a_ff[31];
         div_nq_ff <= a_ff[31] ^ b_ff[31];
         cnt_ff <= '0;
      end
      if (cmd.div_step) begin
         cnt_ff <= cnt_ff + 6'd1;
         if (!trial[32]) begin
            rem_ff <= trial[31:0];
            quo_ff <= {quo_ff[30:0], 1'b1};
         end else begin
            rem_ff <= {rem_ff[30:0], quo_ff[31]};
            quo_ff <= {quo_ff[30:0], 1'b0};
         end
         if (sts.div_done) begin
            if (op_ff == OP_MOD) begin
               res_ff <= !trial[32] ? (div_na_ff ? -trial[31:0] : trial[31:0])
                       : (div_na_ff ? -{rem_ff[30:0], quo_ff[31]} : {rem_ff[30:0], quo_ff[31]});
            end else begin
               res_ff <= div_nq_ff ? -{quo_ff[30:0], !trial[32]} : {quo_ff[30:0], !trial[32]};
            end
         end
      end
      if (cmd.wb) begin
         if (op_ff == OP_PUSH || is_bin || op_ff == OP_LDLOC) begin
            if (sp_ff != SP_W'(STACK_DEPTH)) stack_mem[sp_ff[SA_W-1:0]] <= res_ff;
            else if (err_ff == ST_OK) err_ff <= ST_FULL;
         end
      end
      if (cmd.out) begin
         rsp_top_value <= (op_ff == OP_POP) ? b_ff : (pop_valid ? sp_m1 : 32'd0);
         rsp_depth <= 8'(sp_ff);
         rsp_branch_valid <= bv_ff;
         rsp_next_pc <= npc_ff;
         rsp_status <= err_ff;
      end
   end

   // local store: one write port, shared with the reset clear sweep
   always_ff @(posedge clock) begin
      if (clr_ff != LC_W'(LOCAL_COUNT))
         local_mem[clr_ff[LA_W-1:0]] <= '0;
      else if (cmd.wb && op_ff == OP_STLOC && arg_ok)
         local_mem[arg_ff[LA_W-1:0]] <= b_ff;
   end

   assign out_busy = rsp_valid && !rsp_ready;
endmodule
`default_nettype wire

// ===== dv/smeu_checker.sv =====
// Checker: predicts each response word of the stack machine and compares it with the block.
`default_nettype none
module smeu_checker (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   input  wire logic               req_ready,
   input  wire logic [3:0]         req_opcode,
   input  wire logic [15:0]        req_arg,
   input  wire logic signed [31:0] req_value,
   input  wire logic [15:0]        req_pc,
   input  wire logic               rsp_valid,
   input  wire logic               rsp_ready,
   input  wire logic signed [31:0] rsp_top_value,
   input  wire logic [7:0]         rsp_depth,
   input  wire logic               rsp_branch_valid,
   input  wire logic [15:0]        rsp_next_pc,
   input  wire logic [1:0]         rsp_status,
   output int                      fail_count,
   output int                      pending
);
   import smeu_pkg::*;

   typedef struct packed {
      logic signed [31:0] top_value;
      logic [7:0]         depth;
      logic               branch_valid;
      logic [15:0]        next_pc;
      logic [1:0]         status;
   } rsp_word_type;

   logic [31:0] stk [STACK_DEPTH];
   logic [31:0] locals [LOCAL_COUNT];
   int unsigned sp;
   logic [1:0] err;
   rsp_word_type expected_q[$];

   assign pending = expected_q.size();

   function automatic void push_word(logic [31:0] v);
      if (sp < STACK_DEPTH) begin
         stk[sp] = v;
         sp++;
      end else if (err == ST_OK) begin
         err = ST_FULL;
      end
   endfunction

   function automatic logic [31:0] pop_word();
      if (sp > 0) begin
         sp--;
         return stk[sp];
      end
      if (err == ST_OK) err = ST_UNDER;
      return 0;
   endfunction

   function automatic logic [31:0] divide(logic [31:0] a, logic [31:0] b, bit want_mod);
      logic [31:0] ma, mb, q, r;
      if (b == 0) begin
         if (err == ST_OK) err = ST_DIV0;
         return 0;
      end
      ma = a[31] ? -a : a;
      mb = b[31] ? -b : b;
      q = ma / mb;
      r = ma % mb;
      if (want_mod) return a[31] ? -r : r;
      return (a[31] != b[31]) ? -q : q;
   endfunction

   function automatic rsp_word_type execute(logic [3:0] op, logic [15:0] arg,
                                            logic [31:0] val, logic [15:0] pc);
      rsp_word_type w;
      logic [31:0] a, b, x, res;
      logic signed [31:0] sa, sb;
      bit popped;
      w = '0;
      err = ST_OK;
      popped = 0;
      res = 0;
      case (op)
         OP_PUSH: push_word(val);
         OP_POP: begin
            res = pop_word();
            popped = 1;
         end
         OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_CMP: begin
            b = pop_word();
            a = pop_word();
            sa = a;
            sb = b;
            case (op)
               OP_ADD: x = a + b;
               OP_SUB: x = a - b;
               OP_MUL: x = a * b;
               OP_DIV: x = divide(a, b, 0);
               OP_MOD: x = divide(a, b, 1);
               default: begin
                  case (arg)
                     CMP_LT:  x = {31'd0, sa < sb};
                     CMP_LE:  x = {31'd0, sa <= sb};
                     CMP_NE:  x = {31'd0, sa != sb};
                     CMP_GT:  x = {31'd0, sa > sb};
                     CMP_GE:  x = {31'd0, sa >= sb};
                     default: x = {31'd0, sa == sb};
                  endcase
               end
            endcase
            push_word(x);
         end
         OP_JF: begin
            x = pop_word();
            w.next_pc = (x != 0) ? pc + 16'd2 : arg;
            w.branch_valid = 1;
         end
         OP_JT: begin
            x = pop_word();
            w.next_pc = (x != 0) ? arg : pc + 16'd2;
            w.branch_valid = 1;
         end
         OP_JFWD: begin
            w.next_pc = pc + arg;
            w.branch_valid = 1;
         end
         OP_JABS: begin
            w.next_pc = arg;
            w.branch_valid = 1;
         end
         OP_LDLOC: push_word(arg < LOCAL_COUNT ? locals[arg] : 32'd0);
         OP_STLOC: begin
            x = pop_word();
            if (arg < LOCAL_COUNT) locals[arg] = x;
         end
         OP_TOP: if (sp == 0) err = ST_UNDER;
         default: ;
      endcase
      if (!popped) res = (sp > 0) ? stk[sp-1] : 32'd0;
      w.top_value = res;
      w.depth = sp[7:0];
      w.status = err;
      return w;
   endfunction

   always @(posedge clock) begin
      rsp_word_type got, exp_w;
      if (reset) begin
         sp = 0;
         fail_count = 0;
         expected_q.delete();
         for (int i = 0; i < LOCAL_COUNT; i++) locals[i] = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got = {rsp_top_value, rsp_depth, rsp_branch_valid, rsp_next_pc, rsp_status};
            if (expected_q.size() == 0) begin
               fail_count++;
               if (fail_count <= 10) $display("unexpected word: %h", got);
            end else begin
               exp_w = expected_q.pop_front();
               if (got !== exp_w) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display({"mismatch: exp top=%0d depth=%0d bv=%0b npc=%0d st=%0d,",
                               " got top=%0d depth=%0d bv=%0b npc=%0d st=%0d"},
                              exp_w.top_value, exp_w.depth, exp_w.branch_valid,
                              exp_w.next_pc, exp_w.status, got.top_value, got.depth,
                              got.branch_valid, got.next_pc, got.status);
               end
            end
         end
         if (req_valid && req_ready)
            expected_q.push_back(execute(req_opcode, req_arg, req_value, req_pc));
      end
   end
endmodule
`default_nettype wire

// ===== dv/testbench.sv =====
// Testbench top: stimulus, handshake idling and verdict for the stack machine execute unit.
`default_nettype none
module testbench;
   import smeu_pkg::*;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   logic [3:0] req_opcode = 0;
   logic [15:0] req_arg = 0;
   logic signed [31:0] req_value = 0;
   logic [15:0] req_pc = 0;
   logic rsp_valid;
   logic rsp_ready = 0;
   logic signed [31:0] rsp_top_value;
   logic [7:0] rsp_depth;
   logic rsp_branch_valid;
   logic [15:0] rsp_next_pc;
   logic [1:0] rsp_status;
   int fail_count, pending;
   int idle_cycles = 0;
   bit hold_off = 0;
   int depth_est = 0;

   stack_machine_execute_unit_core u_top (.*);

   smeu_checker u_checker (.*);

   initial forever #5 clock = ~clock;

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // valid stays up between back-to-back words; it drops only ahead of a gap
   task automatic send_word(logic [3:0] op, logic [15:0] arg, logic [31:0] val,
                            logic [15:0] pc);
      int g;
      g = gap_len();
      if (g > 0) begin
         req_valid <= 0;
         repeat (g) @(posedge clock);
      end
      req_valid <= 1;
      req_opcode <= op;
      req_arg <= arg;
      req_value <= val;
      req_pc <= pc;
      do @(posedge clock); while (!req_ready);
      case (op)
         OP_PUSH, OP_LDLOC: if (depth_est < STACK_DEPTH) depth_est++;
         OP_POP, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_CMP, OP_JF, OP_JT, OP_STLOC:
            if (depth_est > 0) depth_est--;
         default: ;
      endcase
   endtask

   function automatic logic [31:0] rand_value();
      case ($urandom_range(0, 7))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'hffff_ffff;
         3: return 0;
         4: return $urandom_range(0, 20) - 10;
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [15:0] rand_arg(logic [3:0] op);
      if (op == OP_CMP)
         return ($urandom_range(0, 9) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 7));
      if (op == OP_LDLOC || op == OP_STLOC)
         return ($urandom_range(0, 9) == 0) ? 16'($urandom())
                                            : 16'($urandom_range(0, LOCAL_COUNT));
      return 16'($urandom());
   endfunction

   // receiver: random stalls, plus the long hold-off when requested
   always @(posedge clock) begin
      if (reset) rsp_ready <= 0;
      else if (hold_off) rsp_ready <= 0;
      else rsp_ready <= ($urandom_range(0, 9) < 7);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 5000) begin
         $display("testbench failed");
         $finish;
      end
   end

   initial begin
      logic [3:0] op;
      int r;
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed: underflow cases, extremes, every operation
      send_word(OP_POP, 0, 0, 0);
      send_word(OP_TOP, 0, 0, 0);
      send_word(OP_ADD, 0, 0, 0);
      send_word(OP_LDLOC, 5, 0, 0);
      send_word(OP_PUSH, 0, 32'h8000_0000, 0);
      send_word(OP_PUSH, 0, 32'hffff_ffff, 0);
      send_word(OP_DIV, 0, 0, 0);
      send_word(OP_PUSH, 0, 32'h8000_0000, 0);
      send_word(OP_PUSH, 0, 32'hffff_ffff, 0);
      send_word(OP_MOD, 0, 0, 0);
      send_word(OP_PUSH, 0, 7, 0);
      send_word(OP_PUSH, 0, 0, 0);
      send_word(OP_DIV, 0, 0, 0);
      send_word(OP_PUSH, 0, 32'h7fff_ffff, 0);
      send_word(OP_MUL, 0, 0, 0);
      send_word(OP_STLOC, 16'hffff, 0, 0);
      send_word(OP_STLOC, 16'(LOCAL_COUNT - 1), 0, 0);
      send_word(OP_LDLOC, 16'(LOCAL_COUNT), 0, 0);
      send_word(OP_JF, 16'hffff, 0, 16'hffff);
      send_word(OP_JT, 16'h1234, 0, 16'hfffe);
      send_word(OP_JFWD, 16'hffff, 0, 16'hffff);
      send_word(OP_JABS, 16'hffff, 0, 0);
      send_word(OP_SUB, 0, 0, 0);
      send_word(OP_CMP, 16'hffff, 0, 0);
      send_word(4'd15, 0, 0, 0);
      // fill the stack to overflow; the receiver holds off as the fill begins
      fork
         begin
            hold_off = 1;
            repeat (300) @(posedge clock);
            hold_off = 0;
         end
         for (int i = 0; i < STACK_DEPTH + 3; i++) send_word(OP_PUSH, 0, rand_value(), 0);
      join
      // sender pause until drained
      req_valid <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      for (int n = 0; n < 1050; n++) begin
         r = $urandom_range(0, 99);
         if (depth_est < 3 && r < 70) op = ($urandom_range(0, 1)) ? OP_PUSH : OP_LDLOC;
         else if (depth_est > 100 && r < 70) op = OP_POP;
         else if (r < 25) op = OP_PUSH;
         else op = 4'($urandom_range(0, 15));
         send_word(op, rand_arg(op), rand_value(), 16'($urandom()));
      end
      req_valid <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (fail_count == 0 && pending == 0) $display("testbench passed");
      else $display("testbench failed");
      $finish;
   end
endmodule
`default_nettype wire

// ===== files.f =====
src/smeu_pkg.sv
src/smeu_ctrl.sv
src/smeu_dp.sv
src/stack_machine_execute_unit_core.sv
dv/smeu_checker.sv
dv/testbench.sv
